### rtl/core/ovl_pkg.sv
// Package for the ordered value list: command and status codes and the
// packed beat types of the input and result channels.
// No dependencies.
package ovl_pkg;

  // Command codes carried in the cmd field of an input beat.
  localparam logic [1:0] CMD_INSERT  = 2'd0;
  localparam logic [1:0] CMD_DELETE  = 2'd1;
  localparam logic [1:0] CMD_DISPLAY = 2'd2;

  // Status codes carried in the status field of a result beat.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EMPTY     = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [31:0] operand_value;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] entry_value;
    logic               last;
  } out_beat_t;

endpackage

### rtl/core/ordered_value_list.sv
// Ordered value list: top level with entry memory and command sequencer.
// Depends on ovl_pkg for the command and status codes and the beat types.
//
// The block keeps up to CAPACITY signed 32-bit values in insertion order in a
// single-port-read memory and serves one command at a time; in_stall_o is high
// while a command is in progress. An insert writes its value at the tail when
// the command is taken unless the list is full, then replies. A delete reads
// the list one entry per cycle until the first match, then closes the gap by
// moving each later entry down one slot, one per cycle. Search and move
// together visit each of the N entries once, whether or not the value is
// found. A display emits one result beat per entry, head first, at one beat
// per cycle when the output is not stalled. A delete or a display on an empty
// list goes straight to a reply with the empty status. The walks are paced by
// the one read port of the entry memory and its registered read data. A
// finished result sits in an output register, so the next command is accepted
// while it waits. Unused command codes are taken and dropped without a result.
// Entries need no clearing after reset: no slot at or past the count is used.
module ordered_value_list
  import ovl_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_beat_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_beat_t out_data_o
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CapCount = CW'(CAPACITY);

  typedef enum logic [2:0] {
    IDLE,
    REPLY,
    SEARCH,
    SHIFT,
    DISPLAY
  } state_e;

  state_e             state_q, state_d;
  logic [AW-1:0]      idx_q, idx_d;
  logic [CW-1:0]      count_q, count_d;
  logic [1:0]         status_q, status_d;
  logic signed [31:0] val_q, val_d;
  logic               out_valid_q, out_valid_d;
  out_beat_t          out_data_q, out_data_d;

  // Entry memory with one write port and one registered read port.
  logic signed [31:0] mem_q [CAPACITY];
  logic signed [31:0] rd_data_q;
  logic [AW-1:0]      rd_addr;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic signed [31:0] mem_wdata;

  logic [CW:0]        idx_p1;
  logic [CW:0]        idx_p2;
  logic [CW:0]        cnt_ext;
  logic               out_free;

  assign idx_p1   = (CW + 1)'(idx_q) + (CW + 1)'(1);
  assign idx_p2   = (CW + 1)'(idx_q) + (CW + 1)'(2);
  assign cnt_ext  = (CW + 1)'(count_q);
  assign out_free = !out_valid_q || !out_stall_i;

  assign in_stall_o  = (state_q != IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rd_data_q <= mem_q[rd_addr];
  end

  // Sequencer: decode a command, walk the memory one slot per unstalled cycle.
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    count_d     = count_q;
    status_d    = status_q;
    val_d       = val_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_data_d  = out_data_q;
    mem_we      = 1'b0;
    mem_waddr   = idx_q;
    mem_wdata   = rd_data_q;
    rd_addr     = '0;

    unique case (state_q)
      IDLE: begin
        idx_d = '0;
        if (in_valid_i) begin
          val_d = in_data_i.operand_value;
          unique case (in_data_i.cmd)
            CMD_INSERT: begin
              state_d = REPLY;
              if (count_q == CapCount) begin
                status_d = ST_FULL;
              end else begin
                status_d  = ST_OK;
                mem_we    = 1'b1;
                mem_waddr = count_q[AW-1:0];
                mem_wdata = in_data_i.operand_value;
                count_d   = count_q + CW'(1);
              end
            end
            CMD_DELETE: begin
              if (count_q == '0) begin
                status_d = ST_EMPTY;
                state_d  = REPLY;
              end else begin
                state_d = SEARCH;
              end
            end
            CMD_DISPLAY: begin
              if (count_q == '0) begin
                status_d = ST_EMPTY;
                state_d  = REPLY;
              end else begin
                state_d = DISPLAY;
              end
            end
            default: begin
              state_d = IDLE;
            end
          endcase
        end
      end

      REPLY: begin
        if (out_free) begin
          out_valid_d            = 1'b1;
          out_data_d.status      = status_q;
          out_data_d.entry_value = '0;
          out_data_d.last        = 1'b1;
          state_d                = IDLE;
        end
      end

      // The read data holds the entry at idx_q.
      SEARCH: begin
        rd_addr = idx_p1[AW-1:0];
        if (rd_data_q == val_q) begin
          if (idx_p1 == cnt_ext) begin
            count_d  = count_q - CW'(1);
            status_d = ST_OK;
            state_d  = REPLY;
          end else begin
            state_d = SHIFT;
          end
        end else if (idx_p1 == cnt_ext) begin
          status_d = ST_NOT_FOUND;
          state_d  = REPLY;
        end else begin
          idx_d = idx_p1[AW-1:0];
        end
      end

      // The read data holds the entry at idx_q + 1; it moves down one slot.
      SHIFT: begin
        rd_addr   = idx_p2[AW-1:0];
        mem_we    = 1'b1;
        mem_waddr = idx_q;
        mem_wdata = rd_data_q;
        if (idx_p2 == cnt_ext) begin
          count_d  = count_q - CW'(1);
          status_d = ST_OK;
          state_d  = REPLY;
        end else begin
          idx_d = idx_p1[AW-1:0];
        end
      end

      // The read data holds the entry at idx_q; it is reread while stalled.
      DISPLAY: begin
        rd_addr = idx_q;
        if (out_free) begin
          rd_addr                = idx_p1[AW-1:0];
          out_valid_d            = 1'b1;
          out_data_d.status      = ST_OK;
          out_data_d.entry_value = rd_data_q;
          out_data_d.last        = (idx_p1 == cnt_ext);
          if (idx_p1 == cnt_ext) begin
            state_d = IDLE;
          end else begin
            idx_d = idx_p1[AW-1:0];
          end
        end
      end

      default: begin
        state_d = IDLE;
      end
    endcase
  end

  // State, counters and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    status_q   <= status_d;
    val_q      <= val_d;
    out_data_q <= out_data_d;
  end

endmodule

### rtl/core/ovl_checker.sv
// Port-level checks for the ordered value list, bound to its top level.
// Depends on ovl_pkg and on the ports of ordered_value_list.
module ovl_checker
  import ovl_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input in_beat_t  in_data_i,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_beat_t out_data_o
);

  // A stalled result beat stays up and unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result beat changed");

  // A command with a defined code keeps the block busy in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o &&
    (in_data_i.cmd == CMD_INSERT || in_data_i.cmd == CMD_DELETE ||
     in_data_i.cmd == CMD_DISPLAY) |=> in_stall_o)
    else $error("block took a command and was not busy after it");

  // Any status other than ok ends the command's results.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status != ST_OK) |-> out_data_o.last)
    else $error("error status without last");

  // A beat with a status other than ok carries a zero entry value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status != ST_OK) |-> (out_data_o.entry_value == '0))
    else $error("status beat carries a nonzero entry value");

endmodule

bind ordered_value_list ovl_checker u_ovl_checker (.*);
